// ----- src/mre_pkg.sv -----
// Shared types, constants and the half-step decode table for the
// multi-encoder rotary decoder. No dependencies.
`default_nettype none

package mre_pkg;

  // Encoders serviced by the round-robin
  localparam int unsigned NUM_ENCODERS = 5;
  localparam int unsigned EncIdxW      = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1;

  // Field widths
  localparam int unsigned PinW    = 5;
  localparam int unsigned CountW  = 3;
  localparam int unsigned PosW    = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 16;

  // Register reset values
  localparam logic [CountW-1:0] EncCountRst = 3'd1;
  localparam logic [PosW-1:0]   MaxPosRst   = 16'd96;
  localparam logic [PosW-1:0]   MaxHoldRst  = 16'd0;
  localparam logic [PosW-1:0]   LogIncRst   = 16'd682;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_ENCODER_COUNT     = 3'd0,
    REG_REV_LENGTH        = 3'd1,
    REG_MAX_HOLD          = 3'd2,
    REG_LOGICAL_INCREMENT = 3'd3
  } cfg_reg_e;

  // Held turn direction
  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_CW   = 2'd1,
    DIR_CCW  = 2'd2
  } dir_e;

  // Decoder phase encoding and table word flags
  localparam logic [2:0] PhaseStart = 3'd0;
  localparam logic [5:0] FlagCw     = 6'h10;
  localparam logic [5:0] FlagCcw    = 6'h20;

  // One half-step table lookup: bits 5:4 flags, bits 2:0 next phase.
  // Phases six and seven decode as the start phase.
  function automatic logic [5:0] step_lookup(logic [2:0] phase, logic [1:0] pins);
    logic [5:0] word;
    case ({phase, pins})
      5'b000_00: word = 6'h03;
      5'b000_01: word = 6'h02;
      5'b000_10: word = 6'h01;
      5'b000_11: word = 6'h00;
      5'b001_00: word = 6'h23;
      5'b001_01: word = 6'h00;
      5'b001_10: word = 6'h01;
      5'b001_11: word = 6'h00;
      5'b010_00: word = 6'h13;
      5'b010_01: word = 6'h02;
      5'b010_10: word = 6'h00;
      5'b010_11: word = 6'h00;
      5'b011_00: word = 6'h03;
      5'b011_01: word = 6'h05;
      5'b011_10: word = 6'h04;
      5'b011_11: word = 6'h00;
      5'b100_00: word = 6'h03;
      5'b100_01: word = 6'h03;
      5'b100_10: word = 6'h04;
      5'b100_11: word = 6'h10;
      5'b101_00: word = 6'h03;
      5'b101_01: word = 6'h05;
      5'b101_10: word = 6'h03;
      5'b101_11: word = 6'h20;
      5'b110_00, 5'b111_00: word = 6'h03;
      5'b110_01, 5'b111_01: word = 6'h02;
      5'b110_10, 5'b111_10: word = 6'h01;
      default:   word = 6'h00;
    endcase
    return word;
  endfunction

endpackage

`default_nettype wire

// ----- src/multi_rotary_encoder_decoder.sv -----
// Top level of the multi-encoder half-step rotary decoder.
// Depends on mre_pkg for widths, register indexes and the decode table.
//
// Usage: each input word carries the A and B pin levels of all encoders,
// sampled once per tick. The block services one encoder per word, chosen
// round-robin, and returns exactly one result word per input word: the
// serviced index, its physical and logical position, its held direction
// and a step flag. The pointer stays on an encoder that just stepped.
// The word sits in the input register, and once the result register is
// free the decode, position update and per-encoder state write land in
// the result register. Throughput is one word per cycle while the
// receiver does not stall; the state update feeds the next word directly.
// When the receiver stalls, the result register holds and the input
// register takes one more word, after which in_ready_o drops.
// The configuration port always accepts; the user must make writes only
// while the block is idle, which the block does not enforce. Writing the
// revolution length presets every position to a quarter of it.
// Reset clears all encoder state, the pointer and both pipeline stages
// and loads the default register values.
`default_nettype none

module multi_rotary_encoder_decoder (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  // input words
  input  wire                            in_valid_i,
  output logic                           in_ready_o,
  input  wire  [mre_pkg::PinW-1:0]       phase_a_levels_i,
  input  wire  [mre_pkg::PinW-1:0]       phase_b_levels_i,
  // result words
  output logic                           out_valid_o,
  input  wire                            out_ready_i,
  output logic [mre_pkg::CountW-1:0]     serviced_encoder_o,
  output logic [mre_pkg::PosW-1:0]       physical_position_o,
  output logic [mre_pkg::PosW-1:0]       logical_position_o,
  output logic [1:0]                     turn_direction_o,
  output logic                           step_seen_o,
  // configuration writes
  input  wire                            cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire  [mre_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire  [mre_pkg::CfgW-1:0]       cfg_data_i
);

  import mre_pkg::*;

  // Configuration registers
  logic [CountW-1:0] enc_count_q;
  logic [PosW-1:0]   max_pos_q;
  logic [PosW-1:0]   max_hold_q;
  logic [PosW-1:0]   log_inc_q;

  // Per-encoder state
  logic [2:0]      phase_q [NUM_ENCODERS];
  logic [PosW-1:0] pos_q   [NUM_ENCODERS];
  logic [PosW-1:0] lpos_q  [NUM_ENCODERS];
  dir_e            dir_q   [NUM_ENCODERS];
  logic [PosW-1:0] timer_q [NUM_ENCODERS];
  logic [EncIdxW-1:0] ptr_q, ptr_d;

  // Input register
  logic            in_valid_q;
  logic [PinW-1:0] a_q, b_q;

  // Datapath
  logic            fire;
  logic            cfg_fire;
  logic [1:0]      pins;
  logic [5:0]      tbl_word;
  logic            step;
  logic [2:0]      phase_d;
  logic [PosW-1:0] pos_d, lpos_d, timer_d;
  dir_e            dir_d;
  logic [PosW:0]   pos_inc;
  logic [CountW:0] count_clamped;
  logic [CountW:0] ptr_inc;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i;

  // Compute when an input word waits and the result register is free
  assign fire       = in_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;

  // Decode the serviced encoder and work out its next state
  always_comb begin
    pins     = {b_q[ptr_q], a_q[ptr_q]};
    tbl_word = step_lookup(phase_q[ptr_q], pins);
    phase_d  = tbl_word[2:0];
    step     = |(tbl_word & (FlagCw | FlagCcw));
    pos_inc  = {1'b0, pos_q[ptr_q]} + {{PosW{1'b0}}, 1'b1};

    // count down the hold, drop the direction once it has run out
    if (timer_q[ptr_q] != '0) begin
      timer_d = timer_q[ptr_q] - {{(PosW-1){1'b0}}, 1'b1};
      dir_d   = dir_q[ptr_q];
    end else begin
      timer_d = timer_q[ptr_q];
      dir_d   = DIR_NONE;
    end

    pos_d  = pos_q[ptr_q];
    lpos_d = lpos_q[ptr_q];
    if (step) begin
      timer_d = max_hold_q;
      if ((tbl_word & (FlagCw | FlagCcw)) == FlagCw) begin
        dir_d  = DIR_CW;
        pos_d  = (pos_inc >= {1'b0, max_pos_q}) ? '0 : pos_inc[PosW-1:0];
        lpos_d = lpos_q[ptr_q] + log_inc_q;
      end else begin
        dir_d  = DIR_CCW;
        pos_d  = (pos_q[ptr_q] == '0 || pos_q[ptr_q] >= max_pos_q) ?
                 (max_pos_q - {{(PosW-1){1'b0}}, 1'b1}) :
                 (pos_q[ptr_q] - {{(PosW-1){1'b0}}, 1'b1});
        lpos_d = lpos_q[ptr_q] - log_inc_q;
      end
    end

    // hold the pointer after a step, else advance and wrap
    count_clamped = ({1'b0, enc_count_q} > (CountW+1)'(NUM_ENCODERS)) ?
                    (CountW+1)'(NUM_ENCODERS) : {1'b0, enc_count_q};
    ptr_inc = (CountW+1)'(ptr_q) + {{CountW{1'b0}}, 1'b1};
    if (step) begin
      ptr_d = ptr_q;
    end else if (ptr_inc >= count_clamped) begin
      ptr_d = '0;
    end else begin
      ptr_d = ptr_inc[EncIdxW-1:0];
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      a_q <= phase_a_levels_i;
      b_q <= phase_b_levels_i;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enc_count_q <= EncCountRst;
      max_pos_q   <= MaxPosRst;
      max_hold_q  <= MaxHoldRst;
      log_inc_q   <= LogIncRst;
    end else if (cfg_fire) begin
      case (cfg_index_i)
        REG_ENCODER_COUNT:     enc_count_q <= cfg_data_i[CountW-1:0];
        REG_REV_LENGTH:        max_pos_q   <= cfg_data_i[PosW-1:0];
        REG_MAX_HOLD:          max_hold_q  <= cfg_data_i[PosW-1:0];
        REG_LOGICAL_INCREMENT: log_inc_q   <= cfg_data_i[PosW-1:0];
        default: ;
      endcase
    end
  end

  // Per-encoder state: update the serviced entry, preset positions on write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_ENCODERS; i++) begin
        phase_q[i] <= PhaseStart;
        pos_q[i]   <= '0;
        lpos_q[i]  <= '0;
        dir_q[i]   <= DIR_NONE;
        timer_q[i] <= '0;
      end
      ptr_q <= '0;
    end else if (cfg_fire && cfg_index_i == REG_REV_LENGTH) begin
      for (int i = 0; i < NUM_ENCODERS; i++) begin
        pos_q[i] <= {2'b00, cfg_data_i[PosW-1:2]};
      end
    end else if (fire) begin
      phase_q[ptr_q] <= phase_d;
      pos_q[ptr_q]   <= pos_d;
      lpos_q[ptr_q]  <= lpos_d;
      dir_q[ptr_q]   <= dir_d;
      timer_q[ptr_q] <= timer_d;
      ptr_q          <= ptr_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (fire) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      serviced_encoder_o  <= CountW'(ptr_q);
      physical_position_o <= pos_d;
      logical_position_o  <= lpos_d;
      turn_direction_o    <= dir_d;
      step_seen_o         <= step;
    end
  end

  // A reported step always carries a direction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && step_seen_o) |-> (turn_direction_o != DIR_NONE))
    else $error("step reported without direction");

  // The serviced index stays within the encoder range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (serviced_encoder_o < CountW'(NUM_ENCODERS)))
    else $error("serviced encoder out of range");

  // The pointer stays on an encoder that just stepped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && step && !cfg_fire) |=> (ptr_q == $past(ptr_q)))
    else $error("pointer moved after a step");

  // A computed word shows up as a valid result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_o)
    else $error("result lost");

endmodule

`default_nettype wire

// ----- tb/sv/multi_rotary_encoder_decoder_tb.sv -----
// Self-checking testbench for the multi-encoder half-step rotary decoder.
// Holds its own decoder model and compares each result word with it;
// depends on mre_pkg and the multi_rotary_encoder_decoder RTL.
`timescale 1ns / 1ps

module multi_rotary_encoder_decoder_tb;
  import mre_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned HoldOffLen  = 80;

  // Indexes past the register list; writes there are dropped
  localparam logic [CfgIdxW-1:0] RegIdxFirstUnused = 3'd4;
  localparam logic [CfgIdxW-1:0] RegIdxLastUnused  = 3'd7;

  // Pin pairs {B,A} along the quadrature cycle; a rising index is clockwise
  localparam logic [7:0] GrayPins = {2'd2, 2'd0, 2'd1, 2'd3};

  typedef struct packed {
    logic [CountW-1:0] encoder;
    logic [PosW-1:0]   phys_pos;
    logic [PosW-1:0]   logical_pos;
    dir_e              dir;
    logic              step;
  } tick_result_t;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_e;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  logic [PinW-1:0]     phase_a   = '0;
  logic [PinW-1:0]     phase_b   = '0;
  logic                out_valid;
  logic                out_ready = 1'b1;
  logic [CountW-1:0]   serviced_enc;
  logic [PosW-1:0]     phys_pos;
  logic [PosW-1:0]     logic_pos;
  logic [1:0]          turn_dir;
  logic                step_seen;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgW-1:0]     cfg_data  = '0;

  // Decoder model state
  logic [2:0]          enc_phase   [NUM_ENCODERS];
  logic [PosW-1:0]     enc_pos     [NUM_ENCODERS];
  logic [PosW-1:0]     enc_logical [NUM_ENCODERS];
  dir_e                enc_dir     [NUM_ENCODERS];
  logic [PosW-1:0]     enc_hold    [NUM_ENCODERS];
  int unsigned         svc_ptr;
  logic [CountW-1:0]   cfg_count;
  logic [PosW-1:0]     cfg_max_pos;
  logic [PosW-1:0]     cfg_max_hold;
  logic [PosW-1:0]     cfg_increment;

  tick_result_t        expected_ticks [$];
  int unsigned         error_count = 0;
  int unsigned         cycle_count = 0;

  // Stimulus state: quadrature position and spin of each encoder
  int unsigned         gray_idx [NUM_ENCODERS];
  bit                  spin_cw  [NUM_ENCODERS];
  int unsigned         burst_left = 0;

  // Receiver stall control
  bit                  holdoff_req  = 1'b0;
  int unsigned         holdoff_left = 0;
  rx_mode_e            rx_mode      = RX_ALWAYS;
  int unsigned         rx_mode_left = 0;
  int unsigned         rx_tick      = 0;

  multi_rotary_encoder_decoder u_dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .phase_a_levels_i    (phase_a),
    .phase_b_levels_i    (phase_b),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .serviced_encoder_o  (serviced_enc),
    .physical_position_o (phys_pos),
    .logical_position_o  (logic_pos),
    .turn_direction_o    (turn_dir),
    .step_seen_o         (step_seen),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data)
  );

  always #1 clk = ~clk;

  // Half-step decode: bits 5:4 step flags, bits 2:0 next phase
  function automatic logic [5:0] decode_word(logic [2:0] phase, logic [1:0] pins);
    logic [23:0] row;
    case (phase)
      3'd1:    row = {6'h00, 6'h01, 6'h00, 6'h23};
      3'd2:    row = {6'h00, 6'h00, 6'h02, 6'h13};
      3'd3:    row = {6'h00, 6'h04, 6'h05, 6'h03};
      3'd4:    row = {6'h10, 6'h04, 6'h03, 6'h03};
      3'd5:    row = {6'h20, 6'h03, 6'h05, 6'h03};
      default: row = {6'h00, 6'h01, 6'h02, 6'h03};
    endcase
    return row[6*pins +: 6];
  endfunction

  task automatic reset_decoder_model();
    for (int e = 0; e < NUM_ENCODERS; e++) begin
      enc_phase[e]   = PhaseStart;
      enc_pos[e]     = '0;
      enc_logical[e] = '0;
      enc_dir[e]     = DIR_NONE;
      enc_hold[e]    = '0;
      gray_idx[e]    = 0;
      spin_cw[e]     = 1'b1;
    end
    svc_ptr       = 0;
    cfg_count     = EncCountRst;
    cfg_max_pos   = MaxPosRst;
    cfg_max_hold  = MaxHoldRst;
    cfg_increment = LogIncRst;
  endtask

  task automatic apply_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    case (idx)
      REG_ENCODER_COUNT:     cfg_count = data[CountW-1:0];
      REG_REV_LENGTH: begin
        cfg_max_pos = data;
        for (int e = 0; e < NUM_ENCODERS; e++) enc_pos[e] = data >> 2;
      end
      REG_MAX_HOLD:          cfg_max_hold = data;
      REG_LOGICAL_INCREMENT: cfg_increment = data;
      default: ;
    endcase
  endtask

  // Service one encoder for an accepted word and queue the result it gives
  task automatic predict_tick(logic [PinW-1:0] a, logic [PinW-1:0] b);
    int unsigned  e;
    int unsigned  lim;
    int unsigned  p;
    logic [1:0]   pins;
    logic [5:0]   word;
    logic [5:0]   flags;
    tick_result_t r;
    e = svc_ptr;
    if (e >= NUM_ENCODERS) e = 0;
    if (enc_hold[e] != 0) enc_hold[e] = enc_hold[e] - 16'd1;
    else enc_dir[e] = DIR_NONE;
    pins = {b[e], a[e]};
    word = decode_word(enc_phase[e], pins);
    enc_phase[e] = word[2:0];
    flags = word & (FlagCw | FlagCcw);
    if (flags != 0) begin
      p = 32'(enc_pos[e]);
      enc_hold[e] = cfg_max_hold;
      if (flags == FlagCw) begin
        enc_dir[e] = DIR_CW;
        p = (p + 1 >= 32'(cfg_max_pos)) ? 0 : p + 1;
        enc_logical[e] = enc_logical[e] + cfg_increment;
      end else begin
        enc_dir[e] = DIR_CCW;
        p = (p == 0 || p >= 32'(cfg_max_pos)) ? 32'(cfg_max_pos - 16'd1) : p - 1;
        enc_logical[e] = enc_logical[e] - cfg_increment;
      end
      enc_pos[e] = p[PosW-1:0];
    end else begin
      // advance the pointer; an encoder that stepped keeps the service
      lim = (cfg_count > CountW'(NUM_ENCODERS)) ? NUM_ENCODERS : 32'(cfg_count);
      svc_ptr = e + 1;
      if (svc_ptr >= lim) svc_ptr = 0;
    end
    r.encoder     = e[CountW-1:0];
    r.phys_pos    = enc_pos[e];
    r.logical_pos = enc_logical[e];
    r.dir         = enc_dir[e];
    r.step        = (flags != 0);
    expected_ticks.push_back(r);
  endtask

  // Offer one word and hold it until the block takes it
  task automatic send_word(logic [PinW-1:0] a, logic [PinW-1:0] b);
    in_valid <= 1'b1;
    phase_a  <= a;
    phase_b  <= b;
    do @(posedge clk); while (!in_ready);
    predict_tick(a, b);
  endtask

  // Insert a random gap once the current burst runs out
  task automatic pace();
    int unsigned gap;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 8) : $urandom_range(20, 80);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_levels();
    logic [PinW-1:0] a;
    logic [PinW-1:0] b;
    logic [1:0]      pins;
    for (int e = 0; e < PinW; e++) begin
      pins = GrayPins[2*gray_idx[e] +: 2];
      a[e] = pins[0];
      b[e] = pins[1];
    end
    send_word(a, b);
  endtask

  task automatic turn_encoder(int unsigned enc, bit cw);
    gray_idx[enc] = (gray_idx[enc] + (cw ? 1 : 3)) % 4;
    send_levels();
  endtask

  // Move each encoder now and then, slowly enough that it is sampled at
  // every quadrature state most of the time
  task automatic send_gray_word();
    int unsigned lim;
    lim = (cfg_count == 0) ? 1 : (cfg_count > NUM_ENCODERS) ? NUM_ENCODERS : cfg_count;
    for (int e = 0; e < NUM_ENCODERS; e++) begin
      if ($urandom_range(0, 4 * lim) == 0) begin
        if ($urandom_range(0, 5) == 0) spin_cw[e] = !spin_cw[e];
        gray_idx[e] = (gray_idx[e] + (spin_cw[e] ? 1 : 3)) % 4;
      end
    end
    send_levels();
  endtask

  // Drop valid and wait until every expected word is back and the pipe is empty
  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_settings(logic [CountW-1:0] count, logic [PosW-1:0] max_pos,
                                  logic [PosW-1:0] hold, logic [PosW-1:0] inc);
    logic [CfgW-1:0] count_word;
    count_word = ($urandom_range(0, 1) == 0) ? CfgW'(count) :
                 (CfgW'($urandom) & 16'hFFF8) | CfgW'(count);
    write_reg(REG_ENCODER_COUNT, count_word);
    write_reg(REG_REV_LENGTH, max_pos);
    write_reg(REG_MAX_HOLD, hold);
    write_reg(REG_LOGICAL_INCREMENT, inc);
    if ($urandom_range(0, 3) == 0)
      write_reg(CfgIdxW'($urandom_range(RegIdxFirstUnused, RegIdxLastUnused)), CfgW'($urandom));
  endtask

  task automatic program_random_settings();
    logic [CountW-1:0] count;
    logic [PosW-1:0]   max_pos;
    logic [PosW-1:0]   hold;
    logic [PosW-1:0]   inc;
    count = ($urandom_range(0, 9) > 7) ? CountW'(NUM_ENCODERS) : CountW'($urandom_range(0, 7));
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 4))
          0:       max_pos = 16'd0;
          1:       max_pos = 16'd1;
          2:       max_pos = 16'd2;
          3:       max_pos = 16'd65534;
          default: max_pos = 16'd65535;
        endcase
      end
      1, 2, 3: max_pos = PosW'($urandom_range(2, 24));
      4:       max_pos = PosW'($urandom_range(2, 65534));
      default: max_pos = MaxPosRst;
    endcase
    case ($urandom_range(0, 4))
      0:       hold = 16'd0;
      1, 2:    hold = PosW'($urandom_range(1, 12));
      3:       hold = 16'd65535;
      default: hold = PosW'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0:       inc = 16'd0;
      1:       inc = 16'd65535;
      default: inc = PosW'($urandom);
    endcase
    program_settings(count, max_pos, hold, inc);
  endtask

  // Two clockwise and two counterclockwise steps under the reset settings, then three fixed words
  task automatic test_default_turns();
    repeat (4) turn_encoder(0, 1'b1);
    repeat (4) turn_encoder(0, 1'b0);
    send_word(5'h00, 5'h00);
    send_word(5'h1F, 5'h1F);
    send_word(5'h15, 5'h0A);
  endtask

  // Zero count, zero max position, full hold and increment, dropped writes;
  // then a count above the encoder number with a one-position revolution
  task automatic test_register_corners();
    wait_results_done();
    write_reg(REG_ENCODER_COUNT, 16'd0);
    write_reg(REG_REV_LENGTH, 16'd0);
    write_reg(REG_MAX_HOLD, 16'd65535);
    write_reg(REG_LOGICAL_INCREMENT, 16'd65535);
    write_reg(RegIdxFirstUnused, 16'hFFFF);
    write_reg(RegIdxLastUnused, 16'h5A5A);
    repeat (4) turn_encoder(0, 1'b0);
    repeat (2) turn_encoder(0, 1'b1);
    wait_results_done();
    write_reg(REG_ENCODER_COUNT, 16'd7);
    write_reg(REG_REV_LENGTH, 16'd1);
    write_reg(REG_MAX_HOLD, 16'd2);
    write_reg(REG_LOGICAL_INCREMENT, 16'd1);
    repeat (4) turn_encoder(2, 1'b1);
    repeat (3) send_gray_word();
  endtask

  // Phases of fixed and random settings, mostly clean rotation with bursts of noise
  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned noise_len;
    for (int ph = 0; ph < 12; ph++) begin
      wait_results_done();
      if (ph == 0) program_settings(CountW'(NUM_ENCODERS), 16'd2, 16'd0, 16'd0);
      else if (ph == 1) program_settings(CountW'(NUM_ENCODERS), 16'd65534, 16'd65535, 16'd65535);
      else program_random_settings();
      sent = 0;
      while (sent < 125) begin
        if ($urandom_range(0, 9) == 0) begin
          noise_len = $urandom_range(1, 4);
          repeat (noise_len) begin
            send_word(PinW'($urandom), PinW'($urandom));
            pace();
          end
          sent += noise_len;
        end else begin
          send_gray_word();
          pace();
          sent++;
        end
      end
    end
  endtask

  // Hold the result side off while words keep coming, then pause the sender
  task automatic test_output_stall();
    wait_results_done();
    holdoff_req = 1'b1;
    repeat (40) send_gray_word();
    wait_results_done();
    repeat (20) begin
      send_gray_word();
      pace();
    end
  endtask

  // Receiver: long hold-off on request, otherwise a changing stall pattern
  always @(posedge clk) begin
    rx_tick++;
    if (holdoff_req) begin
      holdoff_left = HoldOffLen;
      holdoff_req  = 1'b0;
    end
    if (holdoff_left != 0) begin
      holdoff_left--;
      out_ready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = rx_mode_e'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(20, 200);
      end else begin
        rx_mode_left--;
      end
      case (rx_mode)
        RX_COIN:     out_ready <= ($urandom_range(0, 1) == 0);
        RX_SPARSE:   out_ready <= ($urandom_range(0, 3) == 0);
        RX_PERIODIC: out_ready <= (rx_tick % 3 != 0);
        default:     out_ready <= 1'b1;
      endcase
    end
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  // Compare each accepted result word with the oldest prediction
  always @(posedge clk) begin : check_results
    tick_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_ticks.size() == 0) begin
        $error("result word from encoder %0d with none expected", serviced_enc);
        error_count++;
      end else begin
        want = expected_ticks.pop_front();
        check_field("serviced_encoder", want.encoder, serviced_enc);
        check_field("physical_position", want.phys_pos, phys_pos);
        check_field("logical_position", want.logical_pos, logic_pos);
        check_field("turn_direction", want.dir, turn_dir);
        check_field("step_seen", want.step, step_seen);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    reset_decoder_model();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_default_turns();
    test_register_corners();
    test_random_traffic();
    test_output_stall();
    wait_results_done();
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/mre_pkg.sv
src/multi_rotary_encoder_decoder.sv
tb/sv/multi_rotary_encoder_decoder_tb.sv
